// ----- rtl/core/sha_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message hash package
// Word types, controller/datapath command and status, round constants and
// the SHA-256 mixing functions.
// ----------------------------------------------------------------------------
package sha_pkg;

	// Byte positions within a 64-byte block, the pad byte, the last round and the last digest word
	localparam logic [5:0] LAST_POS = 6'd63;
	localparam logic [5:0] LEN_POS  = 6'd56;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LAST_ROUND = 6'd63;
	localparam logic [1:0] LAST_INDEX = 2'd3;

	// Input word
	typedef struct packed {
		logic [31:0] data_word;
		logic [2:0]  byte_count;
		logic        last;
	} sha_msg_t;

	// Output word
	typedef struct packed {
		logic [63:0] digest_word;
		logic [1:0]  word_index;
		logic        digest_last;
		logic        length_error;
	} sha_dig_t;

	// Source of the byte pushed into the block buffer
	typedef enum logic [1:0] {
		SRC_DATA,
		SRC_PAD,
		SRC_ZERO,
		SRC_LEN
	} sha_src_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH,
		ST_PAD,
		ST_ZERO,
		ST_LEN,
		ST_COMP,
		ST_FOLD,
		ST_DIGEST
	} sha_state_t;

	// Controller to datapath
	typedef struct packed {
		logic       accept;
		logic       push_en;
		sha_src_t   push_sel;
		logic       round_init;
		logic       round_en;
		logic [5:0] round_idx;
		logic       chain_fold;
		logic       digest_load;
	} sha_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [5:0] byte_pos;
		logic [2:0] push_count;
		logic       out_busy;
	} sha_sts_t;

	localparam logic [31:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

endpackage

// ----- rtl/core/sha_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences word acceptance, byte pushes, padding, the 64 compression rounds
// and the digest hand-off to the output register.
// ----------------------------------------------------------------------------
module sha_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             msg_valid,
	input  logic             msg_last,
	output logic             msg_stall,
	output sha_pkg::sha_cmd_t cmd,
	input  sha_pkg::sha_sts_t sts
);
	import sha_pkg::*;

	sha_state_t state_q, state_d;
	sha_state_t ret_q, ret_d;
	logic [2:0] left_q;
	logic       last_q;
	logic [5:0] round_q;
	logic       wrap;

	assign wrap = (sts.byte_pos == LAST_POS);

	// Next state
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		case (state_q)
			ST_IDLE: begin
				if (msg_valid) state_d = ST_PUSH;
			end
			ST_PUSH: begin
				if (left_q == 3'd0) begin
					state_d = last_q ? ST_PAD : ST_IDLE;
				end else if (wrap) begin
					state_d = ST_COMP;
					ret_d   = ST_PUSH;
				end else if (left_q == 3'd1) begin
					state_d = last_q ? ST_PAD : ST_IDLE;
				end
			end
			ST_PAD: begin
				state_d = wrap ? ST_COMP : ST_ZERO;
				ret_d   = ST_ZERO;
			end
			ST_ZERO: begin
				if (sts.byte_pos == LEN_POS) begin
					state_d = ST_LEN;
				end else if (wrap) begin
					state_d = ST_COMP;
					ret_d   = ST_ZERO;
				end
			end
			ST_LEN: begin
				if (wrap) begin
					state_d = ST_COMP;
					ret_d   = ST_DIGEST;
				end
			end
			ST_COMP: begin
				if (round_q == LAST_ROUND) state_d = ST_FOLD;
			end
			ST_FOLD: begin
				state_d = ret_q;
			end
			ST_DIGEST: begin
				if (!sts.out_busy) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Commands
	always_comb begin
		cmd           = '0;
		cmd.push_sel  = SRC_DATA;
		cmd.round_idx = round_q;
		msg_stall     = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				cmd.accept = msg_valid;
			end
			ST_PUSH: begin
				cmd.push_en    = (left_q != 3'd0);
				cmd.round_init = (left_q != 3'd0) && wrap;
			end
			ST_PAD: begin
				cmd.push_en    = 1'b1;
				cmd.push_sel   = SRC_PAD;
				cmd.round_init = wrap;
			end
			ST_ZERO: begin
				cmd.push_en    = (sts.byte_pos != LEN_POS);
				cmd.push_sel   = SRC_ZERO;
				cmd.round_init = wrap;
			end
			ST_LEN: begin
				cmd.push_en    = 1'b1;
				cmd.push_sel   = SRC_LEN;
				cmd.round_init = wrap;
			end
			ST_COMP: begin
				cmd.round_en = 1'b1;
			end
			ST_FOLD: begin
				cmd.chain_fold = 1'b1;
			end
			ST_DIGEST: begin
				cmd.digest_load = !sts.out_busy;
			end
			default: begin
				cmd.accept = 1'b0;
			end
		endcase
	end

	// Hold state, return state, byte count, last flag and round counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			left_q  <= 3'd0;
			last_q  <= 1'b0;
			round_q <= 6'd0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			if (cmd.accept) begin
				left_q <= sts.push_count;
				last_q <= msg_last;
			end else if (state_q == ST_PUSH && cmd.push_en) begin
				left_q <= left_q - 3'd1;
			end
			if (state_q == ST_COMP) round_q <= round_q + 6'd1;
			else                    round_q <= 6'd0;
		end
	end

	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMP && round_q == LAST_ROUND) |=> state_q == ST_FOLD)
		else $error("compression did not end after the last round");

	a_len_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LEN |-> sts.byte_pos[5:3] == 3'b111)
		else $error("length bytes outside the last eight positions");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.digest_load |-> !sts.out_busy)
		else $error("digest loaded while output register busy");

endmodule

// ----- rtl/core/sha_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer and message schedule window, round variables, chaining words,
// bit count and the digest output register.
// ----------------------------------------------------------------------------
module sha_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [31:0]      data_word,
	input  logic [2:0]       byte_count,
	input  sha_pkg::sha_cmd_t cmd,
	output sha_pkg::sha_sts_t sts,
	output logic             dig_valid,
	input  logic             dig_stall,
	output sha_pkg::sha_dig_t dig
);
	import sha_pkg::*;

	logic [31:0] buf_q [16];
	logic [31:0] var_q [8];
	logic [31:0] chain_q [8];
	logic [63:0] bits_q;
	logic [5:0]  pos_q;
	logic        ovf_q;
	logic [31:0] word_q;
	logic [63:0] dig_q [4];
	logic        err_q;
	logic [1:0]  idx_q;
	logic        valid_q;

	logic [2:0]  n_eff;
	logic [64:0] bits_sum;
	logic [7:0]  push_byte;
	logic [31:0] sched_new;
	logic [31:0] t1, t2;

	// Clamp byte count and check the bit count for overflow
	assign n_eff    = byte_count[2] ? 3'd4 : byte_count;
	assign bits_sum = {1'b0, bits_q} + {59'd0, n_eff, 3'b000};

	assign sts.byte_pos   = pos_q;
	assign sts.push_count = (ovf_q || bits_sum[64]) ? 3'd0 : n_eff;
	assign sts.out_busy   = valid_q;

	// Select the byte to push
	always_comb begin
		case (cmd.push_sel)
			SRC_DATA: push_byte = word_q[31:24];
			SRC_PAD:  push_byte = PAD_BYTE;
			SRC_ZERO: push_byte = 8'h00;
			SRC_LEN:  push_byte = bits_q[8 * (7 - pos_q[2:0]) +: 8];
			default:  push_byte = 8'h00;
		endcase
	end

	// Round and schedule arithmetic
	assign sched_new = small_sigma1(buf_q[14]) + buf_q[9] + small_sigma0(buf_q[1]) + buf_q[0];
	assign t1 = var_q[7] + big_sigma1(var_q[4])
		+ ((var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]))
		+ ROUND_K[cmd.round_idx] + buf_q[0];
	assign t2 = big_sigma0(var_q[0])
		+ ((var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]));

	// Write bytes into the block buffer; shift the schedule window per round
	always_ff @(posedge clk) begin
		if (cmd.push_en) begin
			buf_q[pos_q[5:2]][8 * (3 - pos_q[1:0]) +: 8] <= push_byte;
		end else if (cmd.round_en) begin
			for (int i = 0; i < 15; i++) buf_q[i] <= buf_q[i + 1];
			buf_q[15] <= sched_new;
		end
	end

	// Hold the input word and shift it out a byte at a time
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			word_q <= data_word;
		end else if (cmd.push_en && cmd.push_sel == SRC_DATA) begin
			word_q <= {word_q[23:0], 8'h00};
		end
	end

	// Round variables
	always_ff @(posedge clk) begin
		if (cmd.round_init) begin
			for (int i = 0; i < 8; i++) var_q[i] <= chain_q[i];
		end else if (cmd.round_en) begin
			var_q[7] <= var_q[6];
			var_q[6] <= var_q[5];
			var_q[5] <= var_q[4];
			var_q[4] <= var_q[3] + t1;
			var_q[3] <= var_q[2];
			var_q[2] <= var_q[1];
			var_q[1] <= var_q[0];
			var_q[0] <= t1 + t2;
		end
	end

	// Chaining words, bit count, byte position and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= IV[i];
			bits_q <= 64'd0;
			pos_q  <= 6'd0;
			ovf_q  <= 1'b0;
		end else if (cmd.digest_load) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= IV[i];
			bits_q <= 64'd0;
			pos_q  <= 6'd0;
			ovf_q  <= 1'b0;
		end else begin
			if (cmd.chain_fold) begin
				for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + var_q[i];
			end
			if (cmd.accept && !ovf_q) begin
				if (bits_sum[64]) ovf_q  <= 1'b1;
				else              bits_q <= bits_sum[63:0];
			end
			if (cmd.push_en) pos_q <= pos_q + 6'd1;
		end
	end

	// Load the digest register
	always_ff @(posedge clk) begin
		if (cmd.digest_load) begin
			for (int i = 0; i < 4; i++) begin
				dig_q[i] <= ovf_q ? 64'd0 : {chain_q[2 * i], chain_q[2 * i + 1]};
			end
			err_q <= ovf_q;
		end
	end

	// Advance through the four digest words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (cmd.digest_load) begin
			valid_q <= 1'b1;
			idx_q   <= 2'd0;
		end else if (valid_q && !dig_stall) begin
			if (idx_q == LAST_INDEX) valid_q <= 1'b0;
			idx_q <= idx_q + 2'd1;
		end
	end

	assign dig_valid        = valid_q;
	assign dig.digest_word  = dig_q[idx_q];
	assign dig.word_index   = idx_q;
	assign dig.digest_last  = (idx_q == LAST_INDEX);
	assign dig.length_error = err_q;

	a_load_reset: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.digest_load |=> (valid_q && idx_q == 2'd0 && pos_q == 6'd0 && bits_q == 64'd0))
		else $error("digest load did not restart the message state");

	a_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !dig_stall && idx_q == LAST_INDEX) |=> !valid_q)
		else $error("output register still valid after the fourth word");

endmodule

// ----- rtl/core/sha256_message_hash.sv -----
`timescale 1ns / 1ps
// A word is taken, then its message bytes are written one at a time; a full block is
// compressed by 64 rounds and a fold. A last word adds the pad byte, zeros up to byte 56,
// the eight length bytes, one or two block compressions and the digest load. The byte-wide
// buffer write and single round unit stall the input: a new word is taken only once the
// last is done. The digest words drain from their own register while the next message is
// taken. Reset restores the initial hash, bit count and byte position.
// ----------------------------------------------------------------------------
// SHA-256 message hash
// Top level: joins the controller and the datapath.
// ----------------------------------------------------------------------------
module sha256_message_hash (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             msg_valid,
	output logic             msg_stall,
	input  sha_pkg::sha_msg_t msg,
	output logic             dig_valid,
	input  logic             dig_stall,
	output sha_pkg::sha_dig_t dig
);
	import sha_pkg::*;

	sha_cmd_t cmd;
	sha_sts_t sts;

	// Sequence the work
	sha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_last  (msg.last),
		.msg_stall (msg_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Hold and compress the block
	sha_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_word  (msg.data_word),
		.byte_count (msg.byte_count),
		.cmd        (cmd),
		.sts        (sts),
		.dig_valid  (dig_valid),
		.dig_stall  (dig_stall),
		.dig        (dig)
	);

endmodule

// ----- verif/sha256_digest_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 digest checker
// Watches the message and digest channels of the hash block. It keeps its own
// SHA-256 state, works out the four digest words due on every last message
// word and compares each digest word that leaves the block with the oldest one
// still owed.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              msg_valid,
	input  logic              msg_stall,
	input  sha_pkg::sha_msg_t msg,
	input  logic              dig_valid,
	input  logic              dig_stall,
	input  sha_pkg::sha_dig_t dig,
	output int                mismatches,
	output int                outstanding,
	output int                digests_seen
);
	import sha_pkg::*;

	localparam logic [7:0] PAD_MARK    = 8'h80;
	localparam logic [5:0] LENGTH_SLOT = 6'd56;
	localparam logic [2:0] FULL_WORD   = 3'd4;

	localparam logic [31:0] START_CHAIN [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_CONST [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// Running hash state
	logic [31:0] chain [8];
	logic [63:0] msg_bits;
	logic [7:0]  blk [64];
	logic [5:0]  fill;
	logic        len_overflow;

	// Digest words owed by the block, oldest first
	sha_dig_t digest_queue [$];

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// Restore the initial chain and an empty message
	task automatic restart_hash();
		for (int i = 0; i < 8; i++)
			chain[i] = START_CHAIN[i];
		msg_bits     = '0;
		fill         = '0;
		len_overflow = 1'b0;
	endtask

	// Run the 64 rounds over the full block and fold into the chain
	task automatic compress_block();
		logic [31:0] sched [64];
		logic [31:0] va, vb, vc, vd, ve, vf, vg, vh, t1, t2;
		for (int i = 0; i < 16; i++)
			sched[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (int i = 16; i < 64; i++)
			sched[i] = sched[i-16] + sched[i-7]
				+ (rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3))
				+ (rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10));
		va = chain[0]; vb = chain[1]; vc = chain[2]; vd = chain[3];
		ve = chain[4]; vf = chain[5]; vg = chain[6]; vh = chain[7];
		for (int i = 0; i < 64; i++) begin
			t1 = vh + (rotr(ve, 6) ^ rotr(ve, 11) ^ rotr(ve, 25))
				+ ((ve & vf) ^ (~ve & vg)) + ROUND_CONST[i] + sched[i];
			t2 = (rotr(va, 2) ^ rotr(va, 13) ^ rotr(va, 22))
				+ ((va & vb) ^ (va & vc) ^ (vb & vc));
			vh = vg; vg = vf; vf = ve; ve = vd + t1;
			vd = vc; vc = vb; vb = va; va = t1 + t2;
		end
		chain[0] += va; chain[1] += vb; chain[2] += vc; chain[3] += vd;
		chain[4] += ve; chain[5] += vf; chain[6] += vg; chain[7] += vh;
	endtask

	// Place one byte and compress once the block is full
	task automatic absorb_byte(input logic [7:0] b);
		blk[fill] = b;
		if (fill == 6'd63)
			compress_block();
		fill = fill + 6'd1;
	endtask

	// Take one message word; on the last one pad, finish and queue the digest
	task automatic absorb_word(input sha_msg_t m);
		int unsigned n;
		logic [63:0] add_bits;
		sha_dig_t    d;
		n = (m.byte_count > FULL_WORD) ? 4 : m.byte_count;
		add_bits = 64'(n) << 3;
		// drop the bytes once the bit count would wrap
		if (!len_overflow) begin
			if (msg_bits > ~add_bits) begin
				len_overflow = 1'b1;
			end else begin
				msg_bits += add_bits;
				for (int i = 0; i < n; i++)
					absorb_byte(m.data_word[31 - 8*i -: 8]);
			end
		end
		if (m.last) begin
			absorb_byte(PAD_MARK);
			while (fill != LENGTH_SLOT)
				absorb_byte(8'h00);
			for (int i = 0; i < 8; i++)
				absorb_byte(msg_bits[63 - 8*i -: 8]);
			for (int i = 0; i < 4; i++) begin
				d.digest_word  = len_overflow ? 64'd0 : {chain[2*i], chain[2*i+1]};
				d.word_index   = 2'(i);
				d.digest_last  = (i == 3);
				d.length_error = len_overflow;
				digest_queue.push_back(d);
			end
			restart_hash();
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %h, got %h", name, want, got);
			mismatches++;
		end
	endtask

	// Sample both channels mid-cycle, where nothing is moving
	always @(negedge clk) begin : watch
		sha_dig_t want;
		if (!arst_n) begin
			restart_hash();
			digest_queue.delete();
			mismatches   = 0;
			digests_seen = 0;
		end else begin
			if (msg_valid && !msg_stall)
				absorb_word(msg);
			if (dig_valid && !dig_stall) begin
				digests_seen++;
				if (digest_queue.size() == 0) begin
					$error("digest word %h arrived with none expected", dig.digest_word);
					mismatches++;
				end else begin
					want = digest_queue.pop_front();
					check_field("digest_word", want.digest_word, dig.digest_word);
					check_field("word_index", 64'(want.word_index), 64'(dig.word_index));
					check_field("digest_last", 64'(want.digest_last), 64'(dig.digest_last));
					check_field("length_error", 64'(want.length_error),
						64'(dig.length_error));
				end
			end
		end
		outstanding = digest_queue.size();
	end

endmodule

// ----- verif/sha256_message_hash_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message hash testbench
// Feeds directed and random messages into the hash block with bursty input
// and a patterned stall on the digest side, including one long hold-off that
// backs the block up. The digest checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module sha256_message_hash_test;
	import sha_pkg::*;

	localparam int RESET_CYCLES = 7;
	localparam int HOLD_CYCLES  = 600;
	localparam int DRAIN_CYCLES = 250;
	localparam int RANDOM_WORDS = 380;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     msg_valid;
	logic     msg_stall;
	sha_msg_t msg;
	logic     dig_valid;
	logic     dig_stall;
	sha_dig_t dig;

	int mismatches, outstanding, digests_seen;
	int hold_requests = 0;
	int holds_served  = 0;
	int words_sent    = 0;
	int messages_sent = 0;
	int burst_left    = 0;
	bit gaps_on       = 1'b0;

	sha256_message_hash u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg       (msg),
		.dig_valid (dig_valid),
		.dig_stall (dig_stall),
		.dig       (dig)
	);

	sha256_digest_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.msg_valid    (msg_valid),
		.msg_stall    (msg_stall),
		.msg          (msg),
		.dig_valid    (dig_valid),
		.dig_stall    (dig_stall),
		.dig          (dig),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.digests_seen (digests_seen)
	);

	always #6 clk = ~clk;

	// Give up well past the slowest legal run
	initial begin
		#(5_000_000);
		$display("RESULT: ERROR");
		$finish;
	end

	// Offer one word, idling first when a burst has run out, and hold until taken
	task automatic send_word(input logic [31:0] data, input logic [2:0] cnt,
			input logic fin);
		sha_msg_t w;
		if (gaps_on && burst_left == 0) begin
			msg_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 10);
		end
		if (burst_left > 0)
			burst_left--;
		w.data_word  = data;
		w.byte_count = cnt;
		w.last       = fin;
		msg       <= w;
		msg_valid <= 1'b1;
		do @(negedge clk); while (msg_stall);
		@(posedge clk);
		words_sent++;
		if (fin)
			messages_sent++;
	endtask

	// Random message; a noisy one has short inner words or an oversized count
	task automatic send_message(input int n_words, input bit noisy);
		logic [2:0] cnt;
		for (int k = 0; k < n_words; k++) begin
			if (k == n_words - 1)
				cnt = noisy ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
			else if (noisy && $urandom_range(0, 2) == 0)
				cnt = 3'($urandom_range(0, 7));
			else
				cnt = 3'd4;
			send_word($urandom, cnt, k == n_words - 1);
		end
	endtask

	// Drop valid and wait until every owed digest word has come out
	task automatic wait_idle();
		msg_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Digest side: stall pattern that changes now and then, plus one long hold
	initial begin : rx_pattern
		int mode, span, hold_left;
		mode      = 0;
		span      = 0;
		hold_left = 0;
		dig_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && holds_served < hold_requests) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
			end
			if (span == 0) begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(20, 200);
			end
			span--;
			if (hold_left > 0) begin
				hold_left--;
				dig_stall <= 1'b1;
			end else begin
				case (mode)
					0: dig_stall <= 1'b0;
					1: dig_stall <= ($urandom_range(0, 3) == 0);
					2: dig_stall <= ($urandom_range(0, 3) != 0);
					default: dig_stall <= ((span % 8) < 3);
				endcase
			end
		end
	end

	// Message side stimulus and verdict
	initial begin : stimulus
		int len, first_random, pick;
		bit saved;
		arst_n    <= 1'b0;
		msg_valid <= 1'b0;
		msg       <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty message, "abc", and a single all-ones word
		send_word(32'h0000_0000, 3'd0, 1'b1);
		send_word(32'h6162_6300, 3'd3, 1'b1);
		send_word(32'hffff_ffff, 3'd4, 1'b1);
		// short and oversized counts mid-message, oversized count on the last word
		send_word(32'h0000_0000, 3'd6, 1'b0);
		send_word(32'h1234_5678, 3'd1, 1'b0);
		send_word(32'h9abc_def0, 3'd2, 1'b0);
		send_word(32'hdead_beef, 3'd0, 1'b0);
		send_word(32'hcafe_f00d, 3'd7, 1'b1);
		// 56 bytes: length no longer fits, so padding spills into a second block
		for (int k = 0; k < 14; k++)
			send_word($urandom, 3'd4, k == 13);
		send_word(32'h8000_0001, 3'd5, 1'b1);

		first_random = words_sent;
		for (int m = 0; words_sent - first_random < RANDOM_WORDS; m++) begin
			if (m % 12 == 0)
				gaps_on = ~gaps_on;
			// back the block up behind a long digest-side hold
			if (m == 6) begin
				saved   = gaps_on;
				gaps_on = 1'b0;
				hold_requests++;
				repeat (5) send_message($urandom_range(1, 3), 1'b0);
				gaps_on = saved;
			end
			if (m % 20 == 19)
				wait_idle();
			pick = $urandom_range(0, 29);
			if (pick == 0)
				len = $urandom_range(24, 40);
			else if (pick < 6)
				len = $urandom_range(9, 20);
			else
				len = $urandom_range(1, 8);
			send_message(len, $urandom_range(0, 9) == 0);
		end

		// Drain and settle
		msg_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Hashed %0d messages from %0d words, checked %0d digest words.",
			messages_sent, words_sent, digests_seen);
		$display("Covered empty, short, oversized-count and two-block padding cases.");
		if (mismatches == 0 && outstanding == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/sha_pkg.sv
rtl/core/sha_ctrl.sv
rtl/core/sha_datapath.sv
rtl/core/sha256_message_hash.sv
verif/sha256_digest_checker.sv
verif/sha256_message_hash_test.sv
